// File: rtl/signed_distance_between_poses_macros.svh
// Assertion macros shared by the signed distance block.
`ifndef SIGNED_DISTANCE_BETWEEN_POSES_MACROS_SVH
`define SIGNED_DISTANCE_BETWEEN_POSES_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SDBP_ASSERT_IMP(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("sdbp check failed");

// Next-cycle implication, checked outside reset.
`define SDBP_ASSERT_NXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("sdbp check failed");

`endif

// File: rtl/sdbp_pkg.sv
// Types and constants of the signed distance block.
package sdbp_pkg;

   localparam int MAX_STEPS = 24;
   localparam int VEC_W     = 32;
   localparam int ANG_W     = 33;
   localparam int ATAN_W    = 30;
   localparam int OUT_W     = 18;

   // 1/K of the CORDIC rotation in Q30
   localparam logic signed [30:0] INV_GAIN_Q30 = 31'sd652032874;

   // Vector in Q12 and angle accumulator (2^31 stands for pi)
   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] z;
   } vec_type;

   // atan(2^-i) in accumulator units
   function automatic logic [ATAN_W-1:0] atan_angle(input int i);
      logic [ATAN_W-1:0] a;
      begin
         case (i)
            0:       a = 30'h20000000;
            1:       a = 30'h12E4051E;
            2:       a = 30'h09FB385B;
            3:       a = 30'h051111D4;
            4:       a = 30'h028B0D43;
            5:       a = 30'h0145D7E1;
            6:       a = 30'h00A2F61E;
            7:       a = 30'h00517C55;
            8:       a = 30'h0028BE53;
            9:       a = 30'h00145F2F;
            10:      a = 30'h000A2F98;
            11:      a = 30'h000517CC;
            12:      a = 30'h00028BE6;
            13:      a = 30'h000145F3;
            14:      a = 30'h0000A2F9;
            15:      a = 30'h0000517C;
            16:      a = 30'h000028BE;
            17:      a = 30'h0000145F;
            18:      a = 30'h00000A2F;
            19:      a = 30'h00000517;
            20:      a = 30'h0000028B;
            21:      a = 30'h00000145;
            22:      a = 30'h000000A2;
            23:      a = 30'h00000051;
            default: a = '0;
         endcase
         return a;
      end
   endfunction

endpackage

// File: rtl/sdbp_prep.sv
// Front stage: displacement, mean heading and half-turn fold.
module sdbp_prep (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic signed [15:0]    first_x,
   input  logic signed [15:0]    first_y,
   input  logic signed [15:0]    first_heading,
   input  logic signed [15:0]    second_x,
   input  logic signed [15:0]    second_y,
   input  logic signed [15:0]    second_heading,
   output logic                  in_take,
   output logic                  out_valid,
   output sdbp_pkg::vec_type     out_vec,
   input  logic                  out_take
);

   logic                  valid_ff, valid_in;
   sdbp_pkg::vec_type     vec_ff, vec_in;
   logic signed [16:0]    dx, dy, hsum;
   logic signed [15:0]    mean, mean_fold;
   logic                  fold;
   logic signed [31:0]    xq, yq;

   assign in_take = !valid_ff || out_take;

   always_comb begin
      dx        = {second_x[15], second_x} - {first_x[15], first_x};
      dy        = {second_y[15], second_y} - {first_y[15], first_y};
      hsum      = {first_heading[15], first_heading} + {second_heading[15], second_heading};
      mean      = hsum[16:1];
      fold      = (mean > 16'sd16384) || (mean < -16'sd16384);
      // a half turn is a flip of the sign bit in 16-bit angle units
      mean_fold = fold ? {~mean[15], mean[14:0]} : mean;
      xq        = {{3{dx[16]}}, dx, 12'b0};
      yq        = {{3{dy[16]}}, dy, 12'b0};
      vec_in.x  = fold ? -xq : xq;
      vec_in.y  = fold ? -yq : yq;
      vec_in.z  = {mean_fold[15], mean_fold, 16'b0};
      valid_in  = in_take ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         vec_ff <= vec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

endmodule

// File: rtl/sdbp_cell.sv
// One CORDIC rotation step with a fixed shift.
module sdbp_cell #(
   parameter int SHIFT = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  sdbp_pkg::vec_type     in_vec,
   output logic                  in_take,
   output logic                  out_valid,
   output sdbp_pkg::vec_type     out_vec,
   input  logic                  out_take
);

   localparam logic [sdbp_pkg::ATAN_W-1:0] ATAN = sdbp_pkg::atan_angle(SHIFT);

   logic                                valid_ff, valid_in;
   sdbp_pkg::vec_type                   vec_ff, vec_in;
   logic signed [sdbp_pkg::VEC_W-1:0]   xs, ys;
   logic signed [sdbp_pkg::ANG_W-1:0]   step_ang;
   logic                                ccw;

   assign in_take = !valid_ff || out_take;

   always_comb begin
      xs       = $signed(in_vec.x) >>> SHIFT;
      ys       = $signed(in_vec.y) >>> SHIFT;
      step_ang = $signed({{(sdbp_pkg::ANG_W-sdbp_pkg::ATAN_W){1'b0}}, ATAN});
      ccw      = !in_vec.z[sdbp_pkg::ANG_W-1];
      vec_in.x = ccw ? $signed(in_vec.x) + ys : $signed(in_vec.x) - ys;
      vec_in.y = ccw ? $signed(in_vec.y) - xs : $signed(in_vec.y) + xs;
      vec_in.z = ccw ? $signed(in_vec.z) - step_ang : $signed(in_vec.z) + step_ang;
      valid_in = in_take ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         vec_ff <= vec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

endmodule

// File: rtl/sdbp_gain.sv
// Gain correction: constant multiply, then round and saturate.
module sdbp_gain (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [sdbp_pkg::VEC_W-1:0]   in_x,
   output logic                                in_take,
   output logic                                out_valid,
   output logic signed [sdbp_pkg::OUT_W-1:0]   out_value,
   input  logic                                out_stall
);

   localparam int PROD_W = 63;

   logic                                prod_valid_ff, prod_valid_in;
   logic signed [PROD_W-1:0]            prod_ff, prod_in;
   logic                                res_valid_ff, res_valid_in;
   logic signed [sdbp_pkg::OUT_W-1:0]   res_ff, res_in;
   logic                                res_take;
   logic signed [PROD_W-1:0]            rounded;
   logic signed [20:0]                  whole;

   assign res_take = !res_valid_ff || !out_stall;
   assign in_take  = !prod_valid_ff || res_take;

   always_comb begin
      prod_in = $signed({{(PROD_W-sdbp_pkg::VEC_W){in_x[sdbp_pkg::VEC_W-1]}}, in_x})
              * $signed({{(PROD_W-31){1'b0}}, sdbp_pkg::INV_GAIN_Q30});
      rounded = prod_ff + (63'sd1 <<< 41);
      whole   = rounded[62:42];
      if (whole > 21'sd131071) begin
         res_in = 18'sd131071;
      end else if (whole < -21'sd131072) begin
         res_in = -18'sd131072;
      end else begin
         res_in = whole[17:0];
      end
      prod_valid_in = in_take ? in_valid : prod_valid_ff;
      res_valid_in  = res_take ? prod_valid_ff : res_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         res_valid_ff  <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         prod_ff <= prod_in;
      end
      if (res_take) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = res_valid_ff;
   assign out_value = res_ff;

endmodule

// File: rtl/signed_distance_between_poses.sv
// An accepted req word reaches rsp_valid through the front stage, one CORDIC cell per
// iteration (up to MAX_STEPS), gain multiply, round and saturate. Throughput: one word
// per cycle while rsp_stall is low; every stage holds its own valid bit and a stalled
// rsp side backs up only as far as the first empty stage, so bubbles get squeezed out.
// Reset: synchronous, active high; clears only the stage valid bits, data is left as is.
// Each word carries a pure function of its own fields; no state passes between words.
`include "signed_distance_between_poses_macros.svh"

module signed_distance_between_poses #(
   parameter int ITERATIONS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_first_x,
   input  logic signed [15:0]  req_first_y,
   input  logic signed [15:0]  req_first_heading,
   input  logic signed [15:0]  req_second_x,
   input  logic signed [15:0]  req_second_y,
   input  logic signed [15:0]  req_second_heading,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [17:0]  rsp_signed_distance
);

   // clamp the step count to what the angle table covers
   localparam int STEPS = (ITERATIONS > sdbp_pkg::MAX_STEPS) ? sdbp_pkg::MAX_STEPS :
                          ((ITERATIONS < 0) ? 0 : ITERATIONS);

   // largest projected distance, the diagonal of the coordinate range
   localparam logic signed [17:0] RSP_LIMIT = 18'sd92682;

   sdbp_pkg::vec_type   chain_vec  [STEPS+1];
   logic [STEPS:0]      chain_valid;
   logic [STEPS:0]      chain_take;
   logic                prep_take;
   logic                rsp_in_range;

   // front stage: form the Q12 vector and the folded mean angle
   sdbp_prep u_prep (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_valid),
      .first_x        (req_first_x),
      .first_y        (req_first_y),
      .first_heading  (req_first_heading),
      .second_x       (req_second_x),
      .second_y       (req_second_y),
      .second_heading (req_second_heading),
      .in_take        (prep_take),
      .out_valid      (chain_valid[0]),
      .out_vec        (chain_vec[0]),
      .out_take       (chain_take[0])
   );

   // stall the req side only when the front stage is full and cannot advance
   assign req_stall = !prep_take;

   // row of rotation cells, cell k shifts by k and hands its word to cell k+1
   for (genvar k = 0; k < STEPS; k++) begin : g_cell
      sdbp_cell #(
         .SHIFT (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_vec    (chain_vec[k]),
         .in_take   (chain_take[k]),
         .out_valid (chain_valid[k+1]),
         .out_vec   (chain_vec[k+1]),
         .out_take  (chain_take[k+1])
      );
   end

   // remove the CORDIC gain, round half up, saturate
   sdbp_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[STEPS]),
      .in_x      (chain_vec[STEPS].x),
      .in_take   (chain_take[STEPS]),
      .out_valid (rsp_valid),
      .out_value (rsp_signed_distance),
      .out_stall (rsp_stall)
   );

   assign rsp_in_range = (rsp_signed_distance <= RSP_LIMIT) &&
                         (rsp_signed_distance >= -RSP_LIMIT);

   // back-pressure reaches the req side only through a completely full row
   `SDBP_ASSERT_IMP(a_stall_only_when_full, req_stall, (&chain_valid))
   // results stay inside the projected-distance range
   `SDBP_ASSERT_IMP(a_result_range, rsp_valid, rsp_in_range)
   // a front-stage word that cannot move is kept
   `SDBP_ASSERT_NXT(a_front_hold, chain_valid[0] && !chain_take[0], chain_valid[0])

endmodule

// File: tb/signed_distance_between_poses_checker.sv
// Checker for signed_distance_between_poses: predicts each projected distance and compares.
module signed_distance_between_poses_checker #(
   parameter int ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [15:0] req_first_x,
   input  logic signed [15:0] req_first_y,
   input  logic signed [15:0] req_first_heading,
   input  logic signed [15:0] req_second_x,
   input  logic signed [15:0] req_second_y,
   input  logic signed [15:0] req_second_heading,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [17:0] rsp_signed_distance,
   output int                 fail_count,
   output int                 pending_count,
   output int                 words_in,
   output int                 words_out
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROT_STEPS = (ITERATIONS > 24) ? 24 : ((ITERATIONS < 0) ? 0 : ITERATIONS);
   localparam longint GAIN_COMP_Q30 = 652032874;
   localparam longint DIST_MAX      = 131071;
   localparam longint DIST_MIN      = -131072;
   localparam longint QUARTER_TURN  = 16384;
   localparam longint HALF_TURN     = 32768;

   // atan(2^-i), with 2^31 standing for pi
   localparam longint ROT_ANGLE [24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
      64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
      64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
   };

   logic signed [17:0] expected_distance_q [$];

   // Rotate the displacement onto the mean heading and keep the x component.
   function automatic logic signed [17:0] project_distance(
      input logic signed [15:0] fx, input logic signed [15:0] fy, input logic signed [15:0] fh,
      input logic signed [15:0] sx, input logic signed [15:0] sy, input logic signed [15:0] sh);
      longint mean_hdg, vx, vy, ang, xs, ys, prod, proj;
      mean_hdg = (longint'(fh) + longint'(sh)) >>> 1;
      vx = (longint'(sx) - longint'(fx)) * 4096;
      vy = (longint'(sy) - longint'(fy)) * 4096;
      // fold headings past a quarter turn back by a half turn
      if (mean_hdg > QUARTER_TURN) begin
         vx = -vx;
         vy = -vy;
         mean_hdg = mean_hdg - HALF_TURN;
      end else if (mean_hdg < -QUARTER_TURN) begin
         vx = -vx;
         vy = -vy;
         mean_hdg = mean_hdg + HALF_TURN;
      end
      ang = mean_hdg * 65536;
      for (int i = 0; i < ROT_STEPS; i++) begin
         xs = vx >>> i;
         ys = vy >>> i;
         if (ang >= 0) begin
            vx  = vx + ys;
            vy  = vy - xs;
            ang = ang - ROT_ANGLE[i];
         end else begin
            vx  = vx - ys;
            vy  = vy + xs;
            ang = ang + ROT_ANGLE[i];
         end
      end
      prod = vx * GAIN_COMP_Q30;
      proj = (prod + (64'sd1 <<< 41)) >>> 42;
      if (proj > DIST_MAX) proj = DIST_MAX;
      if (proj < DIST_MIN) proj = DIST_MIN;
      return proj[17:0];
   endfunction

   always @(posedge clock) begin
      logic signed [17:0] want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_distance_q.push_back(project_distance(req_first_x, req_first_y,
               req_first_heading, req_second_x, req_second_y, req_second_heading));
            words_in++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_distance_q.size() == 0) begin
               $error("signed_distance: no word expected, actual %0d", rsp_signed_distance);
               fail_count++;
            end else begin
               want = expected_distance_q.pop_front();
               words_out++;
               if (rsp_signed_distance !== want) begin
                  $error("signed_distance mismatch: expected %0d, actual %0d",
                         want, rsp_signed_distance);
                  fail_count++;
               end
            end
         end
         pending_count = expected_distance_q.size();
      end
   end

endmodule

// File: tb/signed_distance_between_poses_tb.sv
// Top of the signed_distance_between_poses testbench: clock, reset, stimulus and verdict.
module signed_distance_between_poses_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITERATIONS       = 16;
   localparam int LATENCY          = ITERATIONS + 3;
   localparam int RANDOM_WORDS     = 1400;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int HOLD_AFTER_WORDS = 400;
   localparam int RUN_LIMIT_NS     = 2_000_000;

   typedef struct packed {
      logic signed [15:0] first_x;
      logic signed [15:0] first_y;
      logic signed [15:0] first_heading;
      logic signed [15:0] second_x;
      logic signed [15:0] second_y;
      logic signed [15:0] second_heading;
   } pose_pair_type;

   // headings around the fold points, the zero crossing and the wrap
   localparam logic signed [15:0] HEADING_CORNERS [13] = '{
      -16'sd32768, -16'sd32767, -16'sd16385, -16'sd16384, -16'sd16383, -16'sd1, 16'sd0,
      16'sd1, 16'sd16383, 16'sd16384, 16'sd16385, 16'sd32766, 16'sd32767
   };

   localparam logic signed [15:0] COORD_CORNERS [4] = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd32767};

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_first_x;
   logic signed [15:0] req_first_y;
   logic signed [15:0] req_first_heading;
   logic signed [15:0] req_second_x;
   logic signed [15:0] req_second_y;
   logic signed [15:0] req_second_heading;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [17:0] rsp_signed_distance;

   int fail_count;
   int pending_count;
   int words_in;
   int words_out;

   int sent_words;
   int burst_left;
   int full_cycles;
   bit held_off;

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   signed_distance_between_poses #(.ITERATIONS(ITERATIONS)) u_top (.*);

   signed_distance_between_poses_checker #(.ITERATIONS(ITERATIONS)) u_checker (.*);

   // Count cycles in which the block refused an offered word.
   always @(posedge clock) begin
      if (!reset && req_valid && req_stall) full_cycles++;
   end

   function automatic pose_pair_type make_pair(input int fx, input int fy, input int fh,
                                               input int sx, input int sy, input int sh);
      pose_pair_type p;
      p.first_x        = 16'(fx);
      p.first_y        = 16'(fy);
      p.first_heading  = 16'(fh);
      p.second_x       = 16'(sx);
      p.second_y       = 16'(sy);
      p.second_heading = 16'(sh);
      return p;
   endfunction

   // Fully random poses four times in ten; otherwise mix in near poses, corner headings,
   // equal positions or corner coordinates so each special case keeps showing up.
   function automatic pose_pair_type random_pair();
      pose_pair_type p;
      int            pick;
      p    = {$urandom, $urandom, $urandom};
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1: begin
            p.first_x  = 16'(int'($urandom_range(0, 4000)) - 2000);
            p.first_y  = 16'(int'($urandom_range(0, 4000)) - 2000);
            p.second_x = 16'(int'(p.first_x) + (int'($urandom_range(0, 200)) - 100));
            p.second_y = 16'(int'(p.first_y) + (int'($urandom_range(0, 200)) - 100));
         end
         2, 3: begin
            p.first_heading  = HEADING_CORNERS[$urandom_range(0, 12)];
            p.second_heading = HEADING_CORNERS[$urandom_range(0, 12)];
         end
         4: begin
            p.second_x = p.first_x;
            p.second_y = p.first_y;
         end
         5: begin
            p.first_x  = COORD_CORNERS[$urandom_range(0, 3)];
            p.first_y  = COORD_CORNERS[$urandom_range(0, 3)];
            p.second_x = COORD_CORNERS[$urandom_range(0, 3)];
            p.second_y = COORD_CORNERS[$urandom_range(0, 3)];
         end
         default: ;
      endcase
      return p;
   endfunction

   // Offer one word at the current falling edge and hold it until accepted.
   // Then either keep valid up for the next word of the burst, or drop it
   // for a random gap and start a new burst.
   task automatic drive_word(input pose_pair_type p);
      req_valid          = 1'b1;
      req_first_x        = p.first_x;
      req_first_y        = p.first_y;
      req_first_heading  = p.first_heading;
      req_second_x       = p.second_x;
      req_second_y       = p.second_y;
      req_second_heading = p.second_heading;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_words++;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         // long bursts now and then give stretches with no sender gaps
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 16);
      end
   endtask

   // Stimulus: directed corners first, then the random body, then drain.
   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_first_x        = '0;
      req_first_y        = '0;
      req_first_heading  = '0;
      req_second_x       = '0;
      req_second_y       = '0;
      req_second_heading = '0;
      burst_left         = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // all zero, then equal positions with arbitrary headings
      drive_word(make_pair(0, 0, 0, 0, 0, 0));
      drive_word(make_pair(1234, -567, 5000, 1234, -567, -21000));
      drive_word(make_pair(-32768, -32768, 32767, -32768, -32768, -32768));
      // longest displacements along the diagonal, both directions
      drive_word(make_pair(-32768, -32768, 8192, 32767, 32767, 8192));
      drive_word(make_pair(32767, 32767, 8192, -32768, -32768, 8192));
      drive_word(make_pair(32767, -32768, -8192, -32768, 32767, -8192));
      // full-range x step with zero heading, then the same on y at a right angle
      drive_word(make_pair(-32768, 0, 0, 32767, 0, 0));
      drive_word(make_pair(0, 32767, 16384, 0, -32768, 16384));
      // mean heading on and just past each quarter-turn fold point
      drive_word(make_pair(100, -200, 16384, -3000, 4000, 16384));
      drive_word(make_pair(100, -200, 16384, -3000, 4000, 16386));
      drive_word(make_pair(100, -200, -16384, -3000, 4000, -16384));
      drive_word(make_pair(100, -200, -16385, -3000, 4000, -16385));
      // headings at the extremes, folded by a half turn
      drive_word(make_pair(-32768, 32767, 32767, 32767, -32768, 32767));
      drive_word(make_pair(-32768, 32767, -32768, 32767, -32768, -32768));
      // opposite headings average to about zero, no wrap
      drive_word(make_pair(0, 0, 32767, 5000, 0, -32768));
      drive_word(make_pair(0, 0, -32768, -5000, 7000, 32767));
      // unit steps
      drive_word(make_pair(0, 0, 0, 1, 0, 0));
      drive_word(make_pair(0, 0, 16384, 0, -1, 16384));
      drive_word(make_pair(-1, -1, -1, 0, 0, -1));
      drive_word(make_pair(32767, 32767, 0, 32767, 32766, 1));

      repeat (RANDOM_WORDS) drive_word(random_pair());

      // drop valid and wait for the last words to come out
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY + 8) @(negedge clock);

      $display("covered %0d pose pairs, %0d distances checked, input held off for %0d cycles",
               words_in, words_out, full_cycles);
      $display("included corner headings, fold points, equal positions and a long output stall");
      if (fail_count == 0) begin
         $display("signed_distance_between_poses regression: pass");
      end else begin
         $display("signed_distance_between_poses regression: fail");
      end
      $finish;
   end

   // Receiver: switch among stall patterns in random phases; once, well into
   // the random body, hold off for a long stretch so the pipe fills up.
   initial begin
      int mode;
      int tick;
      rsp_stall = 1'b0;
      held_off  = 1'b0;
      tick      = 0;
      forever begin
         if (!held_off && sent_words >= HOLD_AFTER_WORDS) begin
            held_off  = 1'b1;
            rsp_stall = 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(8, 64)) begin
            case (mode)
               0:       rsp_stall = 1'b0;
               1:       rsp_stall = ($urandom_range(0, 3) == 0);
               2:       rsp_stall = ($urandom_range(0, 9) < 7);
               default: rsp_stall = ((tick % 5) < 2);
            endcase
            tick++;
            @(negedge clock);
         end
      end
   end

   // Bound the run.
   initial begin
      #RUN_LIMIT_NS;
      $display("signed_distance_between_poses regression: fail");
      $finish;
   end

endmodule
